// ===== src/rlfb_pkg.sv =====
// shared types and constants for the rgb led fade and blink driver
package rlfb_pkg;

  localparam int NUM_CH = 3;
  localparam int CH_W   = 8;

  localparam logic [6:0]  PCT_MAX     = 7'd100;
  // floor(x / 100) == (x * 5243) >> 19 for every x up to 255 * 100
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_SET       = 3'd1,
    CMD_INTENSITY = 3'd2,
    CMD_BLINK     = 3'd3,
    CMD_FADE_IN   = 3'd4,
    CMD_FADE_OUT  = 3'd5,
    CMD_OFF       = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    SEQ_IDLE      = 3'd0,
    SEQ_BLINK_ON  = 3'd1,
    SEQ_BLINK_OFF = 3'd2,
    SEQ_FADE_IN   = 3'd3,
    SEQ_FADE_OUT  = 3'd4
  } seq_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_FDIV = 3'd1,
    ST_LVL  = 3'd2,
    ST_MUL  = 3'd3,
    ST_DONE = 3'd4
  } state_t;

  typedef struct packed {
    logic start;
    logic by_pct;
  } lane_ctl_t;

  typedef struct packed {
    logic load;
    logic busy;
    logic rejected;
  } merge_ctl_t;

endpackage

// ===== src/rlfb_div.sv =====
// serial restoring divider, one quotient bit per cycle
module rlfb_div import rlfb_pkg::*; #(
  parameter int DW = 16,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;

  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_diff;
  logic          ge;
  logic [VW-1:0] rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, q_r[DW-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_diff = rem_sh - {1'b0, dvs_r};
    rem_nxt  = ge ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== src/rlfb_lane.sv =====
// one color channel: product, then divide by 100 or by 255
module rlfb_lane import rlfb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  lane_ctl_t       ctl,
  input  logic [CH_W-1:0] a,
  input  logic [CH_W-1:0] b,
  output logic            done,
  output logic [CH_W-1:0] q
);

  logic              v1_r;
  logic              v2_r;
  logic              by_pct_r;
  logic [2*CH_W-1:0] prod_r;
  logic [CH_W-1:0]   q_r;

  logic [28:0]       pct_prod;
  logic [16:0]       sum255;
  logic [CH_W-1:0]   q_nxt;

  always_comb begin
    pct_prod = 29'(prod_r) * 29'(RECIP_100);
    // floor(x / 255) for x up to 255 * 255
    sum255   = 17'(prod_r) + 17'(prod_r[15:8]) + 17'd1;
    q_nxt    = by_pct_r ? pct_prod[RECIP_SHIFT +: CH_W] : sum255[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.start;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod_r   <= 16'(a) * 16'(b);
      by_pct_r <= ctl.by_pct;
    end
    if (v1_r) begin
      q_r <= q_nxt;
    end
  end

  assign done = v2_r;
  assign q    = q_r;

endmodule

// ===== src/rlfb_merge.sv =====
// merges the channel levels into the result register, with optional output inversion
module rlfb_merge import rlfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  merge_ctl_t  ctl,
  input  color_t      drive,
  input  logic        invert,
  output logic        ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic        valid_r;
  logic [23:0] data_r;
  logic [1:0]  user_r;
  color_t      level;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      level[c] = invert ? ~drive[c] : drive[c];
    end
  end

  assign ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= level;
      user_r <= {ctl.rejected, ctl.busy};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

// ===== src/rgb_led_fade_blink_driver_core.sv =====
// top level of the rgb led fade and blink driver
// Each input transfer produces exactly one result transfer. Tick, set color, off,
// no-op, blink and rejected commands go straight to the result register;
// intensity passes the lanes (channel product, then a reciprocal divide by 100).
// A fade command runs the divider, and a tick that moves a fade to its next level
// runs the divider, then the lanes. With DW = max(TICK_BITS, STEP_BITS + 8) (16 at
// the defaults) quotient bits, the serial divider computes dur / steps and
// i * 255 / steps one quotient bit per cycle; the three channel lanes then scale
// the base color by that level. One item is in work at a time; the next is accepted
// once the previous result is in the output register, which may wait on out_tready.
module rgb_led_fade_blink_driver_core import rlfb_pkg::*; #(
  parameter int TICK_BITS = 16,
  parameter int STEP_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,   // invert_drive
  input  logic        in_tvalid,
  output logic        in_tready,
  // red_level, green_level, blue_level, brightness_pct, on_ticks, duration_ticks,
  // fade_steps, zero pad
  input  logic [71:0] in_tdata,
  input  logic [2:0]  in_tuser,    // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // red_drive, green_drive, blue_drive
  output logic [1:0]  out_tuser    // busy_res, rejected
);

  localparam int DW = (TICK_BITS > STEP_BITS + 8) ? TICK_BITS : STEP_BITS + 8;

  state_t                 state_r, state_nxt;
  seq_mode_t              mode_r, mode_nxt;
  color_t                 base_r, base_nxt;
  color_t                 drive_r, drive_nxt;
  logic [STEP_BITS-1:0]   idx_r, idx_nxt;
  logic [STEP_BITS-1:0]   total_r, total_nxt;
  logic [TICK_BITS-1:0]   cd_r, cd_nxt;
  logic [TICK_BITS-1:0]   pend_r, pend_nxt;
  logic                   rej_r, rej_nxt;
  logic                   fade_in_r, fade_in_nxt;
  logic                   ca_r;

  cmd_t                   cmd;
  color_t                 in_rgb;
  logic [6:0]             in_pct;
  logic [6:0]             pct_c;
  logic [TICK_BITS-1:0]   on_t;
  logic [TICK_BITS-1:0]   dur_t;
  logic [STEP_BITS-1:0]   steps_raw;
  logic [STEP_BITS-1:0]   steps_c;
  logic [TICK_BITS-1:0]   cd_dec;
  logic [STEP_BITS-1:0]   idx_step;
  logic                   fade_more;
  logic [STEP_BITS+7:0]   lvl_num;

  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [STEP_BITS-1:0]   div_divisor;
  logic                   div_done;
  logic [DW-1:0]          div_q;
  logic [TICK_BITS-1:0]   div_ticks;

  lane_ctl_t              lane_ctl;
  color_t                 lane_a;
  logic [CH_W-1:0]        lane_b;
  logic [NUM_CH-1:0]      lane_done;
  color_t                 lane_q;

  merge_ctl_t             mrg_ctl;
  logic                   mrg_ready;

  // field unpacking
  always_comb begin
    cmd       = cmd_t'(in_tuser);
    in_rgb    = in_tdata[23:0];
    in_pct    = in_tdata[30:24];
    on_t      = TICK_BITS'(in_tdata[46:31]);
    dur_t     = TICK_BITS'(in_tdata[62:47]);
    steps_raw = STEP_BITS'(in_tdata[70:63]);
    steps_c   = (steps_raw == '0) ? STEP_BITS'(1) : steps_raw;
    pct_c     = (in_pct > PCT_MAX) ? PCT_MAX : in_pct;
    cd_dec    = cd_r - TICK_BITS'(cd_r != '0);
    idx_step  = (mode_r == SEQ_FADE_IN) ? idx_r + 1'b1 : idx_r - 1'b1;
    fade_more = (mode_r == SEQ_FADE_IN) ? (idx_step < total_r) : (idx_step != '0);
    // idx * 255
    lvl_num   = {idx_step, 8'd0} - (STEP_BITS + 8)'(idx_step);
    div_ticks = div_q[TICK_BITS-1:0];
  end

  // intensity scales the incoming color, a fade level scales the stored base
  assign lane_a = (state_r == ST_IDLE) ? in_rgb : base_r;
  assign lane_b = (state_r == ST_IDLE) ? CH_W'(pct_c) : div_q[CH_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    base_nxt      = base_r;
    drive_nxt     = drive_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    cd_nxt        = cd_r;
    pend_nxt      = pend_r;
    rej_nxt       = rej_r;
    fade_in_nxt   = fade_in_r;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = total_r;
    lane_ctl      = '{start: 1'b0, by_pct: 1'b0};
    mrg_ctl       = '{load: 1'b0, busy: (mode_r != SEQ_IDLE), rejected: rej_r};
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          rej_nxt   = 1'b0;
          state_nxt = ST_DONE;
          if (cmd == CMD_TICK) begin
            if (mode_r != SEQ_IDLE) begin
              cd_nxt = cd_dec;
              if (cd_dec == '0) begin
                case (mode_r)
                  SEQ_BLINK_ON: begin
                    drive_nxt = '0;
                    mode_nxt  = (pend_r == '0) ? SEQ_IDLE : SEQ_BLINK_OFF;
                    cd_nxt    = pend_r;
                  end
                  SEQ_FADE_IN, SEQ_FADE_OUT: begin
                    idx_nxt      = idx_step;
                    div_start    = 1'b1;
                    div_dividend = DW'(lvl_num);
                    div_divisor  = total_r;
                    if (fade_more) begin
                      cd_nxt = pend_r;
                    end else begin
                      mode_nxt = SEQ_IDLE;
                      cd_nxt   = '0;
                    end
                    state_nxt = ST_LVL;
                  end
                  default: begin
                    mode_nxt = SEQ_IDLE;
                  end
                endcase
              end
            end
          end else if (cmd == CMD_NOP) begin
            rej_nxt = 1'b0;
          end else if (mode_r != SEQ_IDLE) begin
            rej_nxt = 1'b1;
          end else begin
            case (cmd)
              CMD_SET: begin
                base_nxt  = in_rgb;
                drive_nxt = in_rgb;
              end
              CMD_INTENSITY: begin
                lane_ctl  = '{start: 1'b1, by_pct: 1'b1};
                state_nxt = ST_MUL;
              end
              CMD_BLINK: begin
                base_nxt = in_rgb;
                pend_nxt = dur_t;
                if (on_t == '0) begin
                  drive_nxt = '0;
                  mode_nxt  = (dur_t == '0) ? SEQ_IDLE : SEQ_BLINK_OFF;
                  cd_nxt    = dur_t;
                end else begin
                  drive_nxt = in_rgb;
                  mode_nxt  = SEQ_BLINK_ON;
                  cd_nxt    = on_t;
                end
              end
              CMD_FADE_IN, CMD_FADE_OUT: begin
                base_nxt     = in_rgb;
                total_nxt    = steps_c;
                // keep the step index within the new total while the divide runs
                idx_nxt      = (cmd == CMD_FADE_IN) ? '0 : steps_c;
                fade_in_nxt  = (cmd == CMD_FADE_IN);
                div_start    = 1'b1;
                div_dividend = DW'(dur_t);
                div_divisor  = steps_c;
                state_nxt    = ST_FDIV;
              end
              CMD_OFF: begin
                drive_nxt = '0;
              end
              default: begin
                rej_nxt = 1'b0;
              end
            endcase
          end
        end
      end
      ST_FDIV: begin
        if (div_done) begin
          pend_nxt  = div_ticks;
          state_nxt = ST_DONE;
          if (div_ticks == '0) begin
            // no wait between levels: the whole fade runs now
            mode_nxt  = SEQ_IDLE;
            cd_nxt    = '0;
            idx_nxt   = fade_in_r ? total_r : '0;
            drive_nxt = fade_in_r ? base_r : '0;
          end else begin
            mode_nxt  = fade_in_r ? SEQ_FADE_IN : SEQ_FADE_OUT;
            cd_nxt    = div_ticks;
            idx_nxt   = fade_in_r ? '0 : total_r;
            drive_nxt = fade_in_r ? '0 : base_r;
          end
        end
      end
      ST_LVL: begin
        if (div_done) begin
          lane_ctl  = '{start: 1'b1, by_pct: 1'b0};
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (&lane_done) begin
          drive_nxt = lane_q;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (mrg_ready) begin
          mrg_ctl.load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= SEQ_IDLE;
      base_r    <= '0;
      drive_r   <= '0;
      idx_r     <= '0;
      total_r   <= STEP_BITS'(1);
      cd_r      <= '0;
      pend_r    <= '0;
      rej_r     <= 1'b0;
      fade_in_r <= 1'b0;
      ca_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      base_r    <= base_nxt;
      drive_r   <= drive_nxt;
      idx_r     <= idx_nxt;
      total_r   <= total_nxt;
      cd_r      <= cd_nxt;
      pend_r    <= pend_nxt;
      rej_r     <= rej_nxt;
      fade_in_r <= fade_in_nxt;
      if (cfg_we) begin
        ca_r <= cfg_wdata;
      end
    end
  end

  rlfb_div #(
    .DW (DW),
    .VW (STEP_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    rlfb_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .a     (lane_a[c]),
      .b     (lane_b),
      .done  (lane_done[c]),
      .q     (lane_q[c])
    );
  end

  rlfb_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mrg_ctl),
    .drive      (drive_r),
    .invert     (ca_r),
    .ready      (mrg_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // a running sequence always has time left
  a_busy_has_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != SEQ_IDLE |-> cd_r != '0)
    else $error("sequence running with zero countdown");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= total_r)
    else $error("fade step index beyond step total");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_FDIV || state_r == ST_LVL)
    else $error("divider finished outside a divide state");

  // a rejected command never changes the sequence, so busy stays set
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_ctl.load && mrg_ctl.rejected |-> mrg_ctl.busy)
    else $error("rejected result without busy");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer accepted while one is in work");
`endif

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the rgb led fade and blink driver core
module tb;
  import rlfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  r, g, b;
    logic [6:0]  pct;
    logic [15:0] on_t;
    logic [15:0] dur;
    logic [7:0]  steps;
  } led_cmd_t;

  typedef struct {
    logic [7:0] r, g, b;
    logic       busy;
    logic       rej;
  } led_drive_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  rgb_led_fade_blink_driver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  // led state as the block should hold it
  logic [7:0]  base_c [3];
  logic [7:0]  lvl_c [3];
  seq_mode_t   mode_m;
  int unsigned idx_m;
  int unsigned total_m;
  logic [15:0] countdown_m;
  logic [15:0] wait_m;
  logic        anode_m;

  led_cmd_t    pending_cmds [$];
  led_drive_t  expected_drives [$];
  led_cmd_t    cur_cmd;
  bit          cmd_taken = 1'b0;
  bit          calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cmds_queued = 0;

  function automatic void clear_led_state();
    int k;
    for (k = 0; k < 3; k++) begin
      base_c[k] = '0;
      lvl_c[k]  = '0;
    end
    mode_m      = SEQ_IDLE;
    idx_m       = 0;
    total_m     = 1;
    countdown_m = '0;
    wait_m      = '0;
    anode_m     = 1'b0;
  endfunction

  function automatic void show_fade_level();
    int unsigned lvl;
    int k;
    lvl = (idx_m * 255) / total_m;
    for (k = 0; k < 3; k++) lvl_c[k] = 8'((base_c[k] * lvl) / 255);
  endfunction

  // walk through every level whose wait is zero, stop at the end of the fade
  function automatic void run_fade_levels();
    bit more;
    while (1'b1) begin
      more = (mode_m == SEQ_FADE_IN) ? (idx_m < total_m) : (idx_m > 0);
      if (!more) begin
        mode_m      = SEQ_IDLE;
        countdown_m = '0;
        return;
      end
      if (wait_m != 0) begin
        countdown_m = wait_m;
        return;
      end
      if (mode_m == SEQ_FADE_IN) idx_m++;
      else idx_m--;
      show_fade_level();
    end
  endfunction

  function automatic void end_blink_on();
    int k;
    for (k = 0; k < 3; k++) lvl_c[k] = '0;
    if (wait_m == 0) begin
      mode_m      = SEQ_IDLE;
      countdown_m = '0;
    end else begin
      mode_m      = SEQ_BLINK_OFF;
      countdown_m = wait_m;
    end
  endfunction

  function automatic void tick_led_state();
    if (mode_m == SEQ_IDLE) return;
    if (countdown_m != 0) countdown_m--;
    if (countdown_m != 0) return;
    case (mode_m)
      SEQ_BLINK_ON: end_blink_on();
      SEQ_BLINK_OFF: mode_m = SEQ_IDLE;
      SEQ_FADE_IN: begin
        idx_m++;
        show_fade_level();
        run_fade_levels();
      end
      default: begin
        idx_m--;
        show_fade_level();
        run_fade_levels();
      end
    endcase
  endfunction

  function automatic void take_base(led_cmd_t c);
    base_c[0] = c.r;
    base_c[1] = c.g;
    base_c[2] = c.b;
  endfunction

  function automatic led_drive_t apply_led_command(led_cmd_t c);
    led_drive_t  d;
    int unsigned p;
    int unsigned se;
    logic [7:0]  v [3];
    int k;
    d.rej = 1'b0;
    if (c.cmd == CMD_TICK) begin
      tick_led_state();
    end else if (c.cmd == CMD_NOP) begin
    end else if (mode_m != SEQ_IDLE) begin
      d.rej = 1'b1;
    end else begin
      case (c.cmd)
        CMD_SET: begin
          take_base(c);
          for (k = 0; k < 3; k++) lvl_c[k] = base_c[k];
        end
        CMD_INTENSITY: begin
          p = (c.pct > PCT_MAX) ? 100 : c.pct;
          lvl_c[0] = 8'((c.r * p) / 100);
          lvl_c[1] = 8'((c.g * p) / 100);
          lvl_c[2] = 8'((c.b * p) / 100);
        end
        CMD_BLINK: begin
          take_base(c);
          for (k = 0; k < 3; k++) lvl_c[k] = base_c[k];
          wait_m = c.dur;
          if (c.on_t == 0) begin
            end_blink_on();
          end else begin
            mode_m      = SEQ_BLINK_ON;
            countdown_m = c.on_t;
          end
        end
        CMD_FADE_IN, CMD_FADE_OUT: begin
          take_base(c);
          se      = (c.steps == 0) ? 1 : c.steps;
          total_m = se;
          wait_m  = 16'(c.dur / se);
          mode_m  = (c.cmd == CMD_FADE_IN) ? SEQ_FADE_IN : SEQ_FADE_OUT;
          idx_m   = (c.cmd == CMD_FADE_IN) ? 0 : se;
          show_fade_level();
          run_fade_levels();
        end
        default: for (k = 0; k < 3; k++) lvl_c[k] = '0;
      endcase
    end
    for (k = 0; k < 3; k++) v[k] = anode_m ? 8'd255 - lvl_c[k] : lvl_c[k];
    d.r    = v[0];
    d.g    = v[1];
    d.b    = v[2];
    d.busy = (mode_m != SEQ_IDLE);
    return d;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // mostly short gaps, a few long ones, none at all while calm
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // accept side: predict on every input transfer, check every result transfer
  always @(posedge clk) begin
    led_drive_t want;
    if (!rst_n) begin
      clear_led_state();
    end else begin
      if (cfg_we) anode_m = cfg_wdata;
      if (in_tvalid && in_tready) begin
        expected_drives.push_back(apply_led_command(cur_cmd));
        cmd_taken = 1'b1;
        if ($urandom_range(0, 149) == 0) calm = !calm;
      end
      if (out_tvalid && out_tready) begin
        if (expected_drives.size() == 0) begin
          note_mismatch("result with nothing pending", out_tdata, 0);
        end else begin
          want = expected_drives.pop_front();
          if (out_tdata[7:0] !== want.r) note_mismatch("red_drive", out_tdata[7:0], want.r);
          if (out_tdata[15:8] !== want.g)
            note_mismatch("green_drive", out_tdata[15:8], want.g);
          if (out_tdata[23:16] !== want.b)
            note_mismatch("blue_drive", out_tdata[23:16], want.b);
          if (out_tuser[0] !== want.busy) note_mismatch("busy_res", out_tuser[0], want.busy);
          if (out_tuser[1] !== want.rej) note_mismatch("rejected", out_tuser[1], want.rej);
        end
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_tdata <= {1'b0, cur_cmd.steps, cur_cmd.dur, cur_cmd.on_t, cur_cmd.pct,
                     cur_cmd.b, cur_cmd.g, cur_cmd.r};
        in_tuser <= cur_cmd.cmd;
        in_tvalid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      hold_left = pick_gap();
      out_tready <= (hold_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic queue_cmd(input led_cmd_t c);
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic queue_fields(input cmd_t k, input int unsigned r, input int unsigned g,
                              input int unsigned b, input int unsigned pct,
                              input int unsigned on_t, input int unsigned dur,
                              input int unsigned steps);
    led_cmd_t c;
    c.cmd   = k;
    c.r     = 8'(r);
    c.g     = 8'(g);
    c.b     = 8'(b);
    c.pct   = 7'(pct);
    c.on_t  = 16'(on_t);
    c.dur   = 16'(dur);
    c.steps = 8'(steps);
    queue_cmd(c);
  endtask

  function automatic led_cmd_t random_fields(cmd_t k);
    led_cmd_t c;
    c.cmd   = k;
    c.r     = 8'($urandom_range(0, 255));
    c.g     = 8'($urandom_range(0, 255));
    c.b     = 8'($urandom_range(0, 255));
    c.pct   = 7'($urandom_range(0, 127));
    c.on_t  = 16'($urandom_range(0, 65535));
    c.dur   = 16'($urandom_range(0, 65535));
    c.steps = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic int unsigned short_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 40);
    return 0;
  endfunction

  // keep blink and fade times short; returns the ticks the sequence needs
  function automatic int unsigned tame_timing(inout led_cmd_t c);
    int unsigned se;
    int unsigned w;
    if (c.cmd == CMD_BLINK) begin
      c.on_t = 16'(short_ticks());
      c.dur  = 16'(short_ticks());
      return c.on_t + c.dur;
    end
    if (c.cmd == CMD_FADE_IN || c.cmd == CMD_FADE_OUT) begin
      case ($urandom_range(0, 9))
        0:       c.steps = 8'($urandom_range(200, 255));
        1, 2, 3: c.steps = 8'($urandom_range(9, 40));
        default: c.steps = 8'($urandom_range(0, 8));
      endcase
      se    = (c.steps == 0) ? 1 : c.steps;
      w     = (se > 100) ? $urandom_range(0, 1) : $urandom_range(0, 3);
      c.dur = 16'(se * w + $urandom_range(0, se - 1));
      return se * w;
    end
    return 0;
  endfunction

  task automatic queue_episode();
    led_cmd_t    c;
    led_cmd_t    x;
    int unsigned ticks;
    int unsigned i;
    int unsigned dummy;
    c = random_fields(cmd_t'($urandom_range(0, 7)));
    // noise: a lone item of any kind
    if ($urandom_range(0, 99) < 30) begin
      dummy = tame_timing(c);
      queue_cmd(c);
      return;
    end
    c.cmd = cmd_t'($urandom_range(CMD_SET, CMD_OFF));
    ticks = tame_timing(c);
    queue_cmd(c);
    // a broken sequence stops short and leaves the next commands to be rejected
    if (ticks != 0 && $urandom_range(0, 9) == 0) ticks = $urandom_range(0, ticks - 1);
    for (i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        x = random_fields(cmd_t'($urandom_range(CMD_SET, CMD_NOP)));
        dummy = tame_timing(x);
        queue_cmd(x);
      end
      queue_cmd(random_fields(CMD_TICK));
    end
    if ($urandom_range(0, 4) == 0) queue_cmd(random_fields(CMD_TICK));
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || expected_drives.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // let any running sequence run out so the register sees an idle block
  task automatic settle_led();
    wait_drained();
    while (mode_m != SEQ_IDLE) begin
      repeat (8) queue_cmd(random_fields(CMD_TICK));
      wait_drained();
    end
  endtask

  task automatic write_anode(input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic phase_anode [4];
    int unsigned stop_at;
    int p;
    phase_anode = '{1'b1, 1'b0, 1'b1, 1'b0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_anode(1'b0);
    queue_fields(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_fields(CMD_NOP, 255, 255, 255, 127, 65535, 65535, 255);
    queue_fields(CMD_SET, 255, 255, 255, 127, 65535, 65535, 255);
    queue_fields(CMD_SET, 0, 0, 0, 0, 0, 0, 0);
    queue_fields(CMD_INTENSITY, 255, 128, 1, 127, 0, 0, 0);
    queue_fields(CMD_INTENSITY, 255, 77, 3, 100, 0, 0, 0);
    queue_fields(CMD_INTENSITY, 255, 255, 255, 0, 0, 0, 0);
    queue_fields(CMD_INTENSITY, 255, 255, 255, 99, 0, 0, 0);
    queue_fields(CMD_OFF, 200, 100, 50, 50, 3, 3, 3);
    // blink with zero on and off time ends in its own transfer
    queue_fields(CMD_BLINK, 10, 20, 30, 0, 0, 0, 0);
    queue_fields(CMD_BLINK, 40, 50, 60, 0, 0, 2, 0);
    queue_fields(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_fields(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    // command while busy is rejected, no-op and tick are not
    queue_fields(CMD_BLINK, 255, 0, 128, 0, 1, 1, 0);
    queue_fields(CMD_SET, 1, 2, 3, 0, 0, 0, 0);
    queue_fields(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_fields(CMD_NOP, 0, 0, 0, 0, 0, 0, 0);
    queue_fields(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    // zero steps count as one, zero per-level wait finishes at once
    queue_fields(CMD_FADE_IN, 255, 200, 100, 0, 0, 0, 0);
    queue_fields(CMD_FADE_OUT, 255, 128, 7, 0, 0, 3, 4);
    queue_fields(CMD_FADE_IN, 255, 90, 33, 0, 0, 4, 2);
    queue_fields(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_fields(CMD_FADE_OUT, 9, 9, 9, 0, 0, 1, 1);
    repeat (3) queue_fields(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    settle_led();

    for (p = 0; p < 4; p++) begin
      write_anode(phase_anode[p]);
      stop_at = cmds_queued + 460;
      while (cmds_queued < stop_at) queue_episode();
      settle_led();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rlfb_pkg.sv
src/rlfb_div.sv
src/rlfb_lane.sv
src/rlfb_merge.sv
src/rgb_led_fade_blink_driver_core.sv
dv/tb.sv
